// File: hdl/acpk_pkg.sv
package acpk_pkg;

  localparam int DEFAULT_SAMPLE_BITS = 12;
  localparam int PHASE_W = 16;
  localparam int CFG_IDX_W = 3;

  // 0.08 rad and 6.20 rad at 65536 counts per turn
  localparam logic [PHASE_W-1:0] WINDOW_START_RST = 16'd834;
  localparam logic [PHASE_W-1:0] WINDOW_STOP_RST = 16'd64667;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_WAIT  = 3'd1,
    ST_NOSRC = 3'd2,
    ST_UV    = 3'd3,
    ST_OV    = 3'd4,
    ST_OC    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FLT_NONE    = 3'd0,
    FLT_OV      = 3'd1,
    FLT_AC_OFF  = 3'd2,
    FLT_UV      = 3'd3,
    FLT_LOCKOUT = 3'd4
  } fault_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START = 3'd0,
    REG_WINDOW_STOP  = 3'd1,
    REG_OV_PAIR      = 3'd2,
    REG_NOSRC_PAIR   = 3'd3,
    REG_UV_PAIR      = 3'd4,
    REG_LOCKOUT_PAIR = 3'd5,
    REG_CURRENT_PAIR = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    status_e status;
    fault_e  fault;
  } verdict_t;

endpackage

// File: hdl/acpk_eval.sv
module acpk_eval #(
  parameter int SAMPLE_BITS = acpk_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic [acpk_pkg::PHASE_W-1:0] phase_i,
  input  logic [SAMPLE_BITS-1:0]       voltage_a_i,
  input  logic [SAMPLE_BITS-1:0]       current_a_i,
  input  logic [SAMPLE_BITS-1:0]       current_b_i,
  input  logic [acpk_pkg::PHASE_W-1:0] window_start_i,
  input  logic [acpk_pkg::PHASE_W-1:0] window_stop_i,
  input  logic [2*SAMPLE_BITS-1:0]     ov_pair_i,
  input  logic [2*SAMPLE_BITS-1:0]     nosrc_pair_i,
  input  logic [2*SAMPLE_BITS-1:0]     uv_pair_i,
  input  logic [2*SAMPLE_BITS-1:0]     lockout_pair_i,
  input  logic [2*SAMPLE_BITS-1:0]     current_pair_i,
  input  acpk_pkg::status_e            status_i,
  input  logic [SAMPLE_BITS-1:0]       vmax_i,
  input  logic [SAMPLE_BITS:0]         vmin_i,
  output acpk_pkg::verdict_t           verdict_o,
  output logic [SAMPLE_BITS-1:0]       vmax_o,
  output logic [SAMPLE_BITS:0]         vmin_o
);

  localparam logic [SAMPLE_BITS:0] NoneSeen = {1'b1, {SAMPLE_BITS{1'b0}}};

  logic [SAMPLE_BITS-1:0] cur_hi, cur_lo;
  logic over_current;
  logic ov_hit, nosrc_hit, uv_hit, lockout_hit;

  assign cur_hi = current_pair_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign cur_lo = current_pair_i[SAMPLE_BITS-1:0];

  assign over_current = (current_a_i > cur_hi) || (current_a_i < cur_lo) ||
                        (current_b_i > cur_hi) || (current_b_i < cur_lo);

  // limits compared against the stored peaks, before this beat
  assign ov_hit = (vmax_i > ov_pair_i[2*SAMPLE_BITS-1:SAMPLE_BITS]) &&
                  (vmin_i < {1'b0, ov_pair_i[SAMPLE_BITS-1:0]});
  assign nosrc_hit = (vmax_i < nosrc_pair_i[2*SAMPLE_BITS-1:SAMPLE_BITS]) &&
                     (vmin_i > {1'b0, nosrc_pair_i[SAMPLE_BITS-1:0]});
  assign uv_hit = (vmax_i < uv_pair_i[2*SAMPLE_BITS-1:SAMPLE_BITS]) &&
                  (vmin_i > {1'b0, uv_pair_i[SAMPLE_BITS-1:0]});
  assign lockout_hit = (vmax_i < lockout_pair_i[2*SAMPLE_BITS-1:SAMPLE_BITS]) &&
                       (vmin_i > {1'b0, lockout_pair_i[SAMPLE_BITS-1:0]});

  always_comb begin
    vmax_o = vmax_i;
    vmin_o = vmin_i;
    verdict_o.fault = acpk_pkg::FLT_NONE;
    verdict_o.status = over_current ? acpk_pkg::ST_OC : status_i;
    if (phase_i <= window_start_i) begin
      // new cycle: clear peaks, keep last status
      vmax_o = '0;
      vmin_o = NoneSeen;
      verdict_o.status = status_i;
    end else if (phase_i < window_stop_i) begin
      if (vmax_i < voltage_a_i) begin
        vmax_o = voltage_a_i;
      end
      if (vmin_i > {1'b0, voltage_a_i}) begin
        vmin_o = {1'b0, voltage_a_i};
      end
    end else begin
      if (vmax_i == '0 || vmin_i == NoneSeen) begin
        verdict_o.status = acpk_pkg::ST_WAIT;
      end else if (ov_hit) begin
        verdict_o.status = acpk_pkg::ST_OV;
        verdict_o.fault = acpk_pkg::FLT_OV;
      end else if (nosrc_hit) begin
        verdict_o.status = acpk_pkg::ST_NOSRC;
        verdict_o.fault = acpk_pkg::FLT_AC_OFF;
      end else if (uv_hit) begin
        verdict_o.status = acpk_pkg::ST_UV;
        verdict_o.fault = acpk_pkg::FLT_UV;
      end else begin
        verdict_o.status = acpk_pkg::ST_OK;
        if (lockout_hit) begin
          verdict_o.fault = acpk_pkg::FLT_LOCKOUT;
        end
      end
    end
  end

endmodule

// File: hdl/ac_source_cycle_peak_checker_core.sv
// AC source cycle peak checker.
// Input channel (in_valid_i/in_ready_o) takes one sample set per beat: phase
// angle, phase-A voltage, phase-A and phase-B current. Output channel
// (out_valid_o/out_ready_i) gives one result beat per input beat: grid status,
// fault code and the voltage peaks of the running cycle after that sample.
// Limits and phase window are written through cfg_we_i/cfg_idx_i/cfg_data_i,
// one register per cycle; the user must write them only while no beat is in
// flight, which the block does not enforce. An accepted beat is registered
// in the input register, evaluated against the cycle state and loaded into
// the output register. Throughput is one beat per cycle while the output is
// not stalled. A backpressured result is held in the output register while
// one more beat waits in the input register; in_ready_o drops only when both
// are full. Reset (asynchronous, active low) loads the default limits and
// window, sets status to wait and clears the peaks to none seen.
module ac_source_cycle_peak_checker_core #(
  parameter int SAMPLE_BITS = acpk_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [acpk_pkg::PHASE_W-1:0]           phase_i,
  input  logic [SAMPLE_BITS-1:0]                 voltage_a_i,
  input  logic [SAMPLE_BITS-1:0]                 current_a_i,
  input  logic [SAMPLE_BITS-1:0]                 current_b_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [2:0]                             status_o,
  output logic [2:0]                             fault_code_o,
  output logic [SAMPLE_BITS-1:0]                 peak_high_o,
  output logic [SAMPLE_BITS:0]                   peak_low_o,
  input  logic                                   cfg_we_i,
  input  logic [acpk_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [((2*SAMPLE_BITS > acpk_pkg::PHASE_W) ?
                 2*SAMPLE_BITS : acpk_pkg::PHASE_W)-1:0] cfg_data_i
);

  localparam int PairW = 2 * SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] SMax = '1;
  localparam logic [SAMPLE_BITS-1:0] SMid = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [PairW-1:0] WidePairRst = {SMax, {SAMPLE_BITS{1'b0}}};
  localparam logic [PairW-1:0] MidPairRst = {SMid, SMid};
  localparam logic [SAMPLE_BITS:0] NoneSeen = {1'b1, {SAMPLE_BITS{1'b0}}};

  // configuration
  logic [acpk_pkg::PHASE_W-1:0] window_start_q, window_stop_q;
  logic [PairW-1:0] ov_pair_q, nosrc_pair_q, uv_pair_q, lockout_pair_q, current_pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_start_q <= acpk_pkg::WINDOW_START_RST;
      window_stop_q  <= acpk_pkg::WINDOW_STOP_RST;
      ov_pair_q      <= WidePairRst;
      nosrc_pair_q   <= MidPairRst;
      uv_pair_q      <= MidPairRst;
      lockout_pair_q <= MidPairRst;
      current_pair_q <= WidePairRst;
    end else if (cfg_we_i) begin
      unique case (acpk_pkg::cfg_reg_e'(cfg_idx_i))
        acpk_pkg::REG_WINDOW_START: window_start_q <= cfg_data_i[acpk_pkg::PHASE_W-1:0];
        acpk_pkg::REG_WINDOW_STOP:  window_stop_q  <= cfg_data_i[acpk_pkg::PHASE_W-1:0];
        acpk_pkg::REG_OV_PAIR:      ov_pair_q      <= cfg_data_i[PairW-1:0];
        acpk_pkg::REG_NOSRC_PAIR:   nosrc_pair_q   <= cfg_data_i[PairW-1:0];
        acpk_pkg::REG_UV_PAIR:      uv_pair_q      <= cfg_data_i[PairW-1:0];
        acpk_pkg::REG_LOCKOUT_PAIR: lockout_pair_q <= cfg_data_i[PairW-1:0];
        acpk_pkg::REG_CURRENT_PAIR: current_pair_q <= cfg_data_i[PairW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic s1_valid_q, s1_valid_d;
  logic [acpk_pkg::PHASE_W-1:0] phase_q;
  logic [SAMPLE_BITS-1:0] voltage_a_q, current_a_q, current_b_q;
  logic in_fire, s2_load;

  // result register and cycle state; the peaks and status shown are the state
  logic out_valid_q, out_valid_d;
  acpk_pkg::status_e status_q;
  acpk_pkg::fault_e fault_q;
  logic [SAMPLE_BITS-1:0] vmax_q, vmax_d;
  logic [SAMPLE_BITS:0] vmin_q, vmin_d;
  acpk_pkg::verdict_t verdict;

  assign s2_load = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= acpk_pkg::ST_WAIT;
      vmax_q      <= '0;
      vmin_q      <= NoneSeen;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s2_load) begin
        status_q <= verdict.status;
        vmax_q   <= vmax_d;
        vmin_q   <= vmin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      phase_q     <= phase_i;
      voltage_a_q <= voltage_a_i;
      current_a_q <= current_a_i;
      current_b_q <= current_b_i;
    end
    if (s2_load) begin
      fault_q <= verdict.fault;
    end
  end

  acpk_eval #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_eval (
    .phase_i        (phase_q),
    .voltage_a_i    (voltage_a_q),
    .current_a_i    (current_a_q),
    .current_b_i    (current_b_q),
    .window_start_i (window_start_q),
    .window_stop_i  (window_stop_q),
    .ov_pair_i      (ov_pair_q),
    .nosrc_pair_i   (nosrc_pair_q),
    .uv_pair_i      (uv_pair_q),
    .lockout_pair_i (lockout_pair_q),
    .current_pair_i (current_pair_q),
    .status_i       (status_q),
    .vmax_i         (vmax_q),
    .vmin_i         (vmin_q),
    .verdict_o      (verdict),
    .vmax_o         (vmax_d),
    .vmin_o         (vmin_d)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign fault_code_o = fault_q;
  assign peak_high_o  = vmax_q;
  assign peak_low_o   = vmin_q;

endmodule

// File: hdl/acpk_checker.sv
module acpk_checker #(
  parameter int SAMPLE_BITS = acpk_pkg::DEFAULT_SAMPLE_BITS
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [2:0]             status_o,
  input logic [2:0]             fault_code_o,
  input logic [SAMPLE_BITS-1:0] peak_high_o,
  input logic [SAMPLE_BITS:0]   peak_low_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(fault_code_o) && $stable(peak_high_o) && $stable(peak_low_o))
    else $error("result changed while stalled");

  // with the output stalled and full, only one more beat can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=>
      out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted beyond buffer depth");

  // a fault code only comes with its matching status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_code_o != acpk_pkg::FLT_NONE |->
      (fault_code_o == acpk_pkg::FLT_OV && status_o == acpk_pkg::ST_OV) ||
      (fault_code_o == acpk_pkg::FLT_AC_OFF && status_o == acpk_pkg::ST_NOSRC) ||
      (fault_code_o == acpk_pkg::FLT_UV && status_o == acpk_pkg::ST_UV) ||
      (fault_code_o == acpk_pkg::FLT_LOCKOUT && status_o == acpk_pkg::ST_OK))
    else $error("fault code disagrees with status");

  // no minimum seen means no maximum either
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && peak_low_o[SAMPLE_BITS] |->
      peak_high_o == '0 && peak_low_o[SAMPLE_BITS-1:0] == '0)
    else $error("peak registers inconsistent");

endmodule

bind ac_source_cycle_peak_checker_core acpk_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_acpk_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .fault_code_o (fault_code_o),
  .peak_high_o  (peak_high_o),
  .peak_low_o   (peak_low_o)
);

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int S = acpk_pkg::DEFAULT_SAMPLE_BITS;
  localparam int PHASE_W = acpk_pkg::PHASE_W;
  localparam int CFG_IDX_W = acpk_pkg::CFG_IDX_W;
  localparam int CFG_W = (2 * S > PHASE_W) ? 2 * S : PHASE_W;
  localparam int PAD_W = CFG_W - PHASE_W;
  localparam logic [S:0] NONE_SEEN = (S + 1)'(1 << S);
  localparam int GAP_PCT = 37;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [PHASE_W-1:0] phase;
    logic [S-1:0]       va;
    logic [S-1:0]       ia;
    logic [S-1:0]       ib;
  } sample_t;

  typedef struct {
    acpk_pkg::status_e status;
    acpk_pkg::fault_e  fault;
    logic [S-1:0]      peak_high;
    logic [S:0]        peak_low;
  } verdict_rec_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [PHASE_W-1:0] phase_i = '0;
  logic [S-1:0]       voltage_a_i = '0;
  logic [S-1:0]       current_a_i = '0;
  logic [S-1:0]       current_b_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [2:0]         fault_code_o;
  logic [S-1:0]       peak_high_o;
  logic [S:0]         peak_low_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;

  ac_source_cycle_peak_checker_core #(
    .SAMPLE_BITS(S)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .phase_i     (phase_i),
    .voltage_a_i (voltage_a_i),
    .current_a_i (current_a_i),
    .current_b_i (current_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .fault_code_o(fault_code_o),
    .peak_high_o (peak_high_o),
    .peak_low_o  (peak_low_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  sample_t      sample_q[$];
  verdict_rec_t verdict_q[$];
  int           queued_cnt = 0;
  int           mismatch_cnt = 0;
  int           cycle_cnt = 0;
  int           gap_pct = GAP_PCT;

  // predictor copy of the limits and the cycle state
  logic [PHASE_W-1:0] win_start = acpk_pkg::WINDOW_START_RST;
  logic [PHASE_W-1:0] win_stop = acpk_pkg::WINDOW_STOP_RST;
  logic [CFG_W-1:0]   ov_lim = 24'hFFF000;
  logic [CFG_W-1:0]   nosrc_lim = 24'h800800;
  logic [CFG_W-1:0]   uv_lim = 24'h800800;
  logic [CFG_W-1:0]   lockout_lim = 24'h800800;
  logic [CFG_W-1:0]   current_lim = 24'hFFF000;
  acpk_pkg::status_e  grid_status = acpk_pkg::ST_WAIT;
  logic [S-1:0]       vmax = '0;
  logic [S:0]         vmin = NONE_SEEN;

  function automatic logic beyond(logic [S-1:0] v, logic [CFG_W-1:0] pair);
    return v > pair[2*S-1:S] || v < pair[S-1:0];
  endfunction

  function automatic logic in_band(logic [CFG_W-1:0] pair);
    return vmax < pair[2*S-1:S] && vmin > {1'b0, pair[S-1:0]};
  endfunction

  function automatic verdict_rec_t grid_verdict(sample_t smp);
    verdict_rec_t      r;
    acpk_pkg::status_e st;
    acpk_pkg::fault_e  flt;
    st = grid_status;
    flt = acpk_pkg::FLT_NONE;
    if (beyond(smp.ia, current_lim) || beyond(smp.ib, current_lim)) st = acpk_pkg::ST_OC;
    if (smp.phase <= win_start) begin
      vmax = '0;
      vmin = NONE_SEEN;
      st = grid_status;
    end else if (smp.phase < win_stop) begin
      if (vmax < smp.va) vmax = smp.va;
      if (vmin > {1'b0, smp.va}) vmin = {1'b0, smp.va};
    end else begin
      if (vmax == '0 || vmin == NONE_SEEN) begin
        st = acpk_pkg::ST_WAIT;
      end else if (vmax > ov_lim[2*S-1:S] && vmin < {1'b0, ov_lim[S-1:0]}) begin
        st = acpk_pkg::ST_OV;
        flt = acpk_pkg::FLT_OV;
      end else if (in_band(nosrc_lim)) begin
        st = acpk_pkg::ST_NOSRC;
        flt = acpk_pkg::FLT_AC_OFF;
      end else if (in_band(uv_lim)) begin
        st = acpk_pkg::ST_UV;
        flt = acpk_pkg::FLT_UV;
      end else begin
        st = acpk_pkg::ST_OK;
        if (in_band(lockout_lim)) flt = acpk_pkg::FLT_LOCKOUT;
      end
    end
    grid_status = st;
    r.status = st;
    r.fault = flt;
    r.peak_high = vmax;
    r.peak_low = vmin;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] band(int hi, int lo);
    return {S'(hi), S'(lo)};
  endfunction

  function automatic int pick_current();
    if ($urandom_range(9) == 0) return $urandom_range(0, (1 << S) - 1);
    return 1648 + $urandom_range(0, 800);
  endfunction

  task automatic push_sample(int ph, int va, int ia, int ib);
    sample_t smp;
    smp.phase = PHASE_W'(ph);
    smp.va = S'(va);
    smp.ia = S'(ia);
    smp.ib = S'(ib);
    sample_q.push_back(smp);
    queued_cnt++;
  endtask

  // reset, two tracked samples, classify; currents sit exactly on the default test limits
  task automatic push_class_cycle(int hi, int lo);
    push_sample(100, 2048, 3500, 600);
    push_sample(20000, hi, 3500, 600);
    push_sample(40000, lo, 600, 3500);
    push_sample(65000, 2048, 3500, 600);
  endtask

  // one grid cycle: reset region, a triangle wave through the window, classify; either end sample may be skipped
  task automatic push_cycle();
    int n, amp, ctr, step, ph, p, s, v;
    n = $urandom_range(6, 40);
    amp = $urandom_range(0, 2047);
    ctr = 1848 + int'($urandom_range(0, 400));
    step = 65536 / n;
    for (int k = 0; k < n; k++) begin
      if (k == 0) begin
        if ($urandom_range(9) == 0) continue;
        ph = $urandom_range(0, int'(win_start));
      end else if (k == n - 1) begin
        if ($urandom_range(9) == 0) continue;
        ph = $urandom_range(int'(win_stop), 65535);
      end else begin
        ph = k * step + int'($urandom_range(0, step - 1));
      end
      p = (k * 4096) / n;
      s = (p < 1024) ? p : (p < 3072) ? 2048 - p : p - 4096;
      v = ctr + (amp * s) / 1024 + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > (1 << S) - 1) v = (1 << S) - 1;
      push_sample(ph, v, pick_current(), pick_current());
    end
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) begin
      push_sample($urandom_range(0, 65535), $urandom_range(0, (1 << S) - 1),
                  $urandom_range(0, (1 << S) - 1), $urandom_range(0, (1 << S) - 1));
    end
  endtask

  task automatic run_random(int n_items);
    int target;
    target = queued_cnt + n_items;
    while (queued_cnt < target) begin
      if ($urandom_range(99) < 80) push_cycle();
      else push_noise();
    end
  endtask

  task automatic set_reg(acpk_pkg::cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      acpk_pkg::REG_WINDOW_START: win_start = val[PHASE_W-1:0];
      acpk_pkg::REG_WINDOW_STOP:  win_stop = val[PHASE_W-1:0];
      acpk_pkg::REG_OV_PAIR:      ov_lim = val;
      acpk_pkg::REG_NOSRC_PAIR:   nosrc_lim = val;
      acpk_pkg::REG_UV_PAIR:      uv_lim = val;
      acpk_pkg::REG_LOCKOUT_PAIR: lockout_lim = val;
      acpk_pkg::REG_CURRENT_PAIR: current_lim = val;
      default: ;
    endcase
  endtask

  task automatic program_cfg(int ws, int wst, logic [CFG_W-1:0] ov, logic [CFG_W-1:0] ns,
                             logic [CFG_W-1:0] uv, logic [CFG_W-1:0] lk,
                             logic [CFG_W-1:0] cur);
    // junk above the window width must be ignored
    set_reg(acpk_pkg::REG_WINDOW_START, {PAD_W'($urandom), PHASE_W'(ws)});
    set_reg(acpk_pkg::REG_WINDOW_STOP, {PAD_W'($urandom), PHASE_W'(wst)});
    set_reg(acpk_pkg::REG_OV_PAIR, ov);
    set_reg(acpk_pkg::REG_NOSRC_PAIR, ns);
    set_reg(acpk_pkg::REG_UV_PAIR, uv);
    set_reg(acpk_pkg::REG_LOCKOUT_PAIR, lk);
    set_reg(acpk_pkg::REG_CURRENT_PAIR, cur);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (sample_q.size() != 0 || verdict_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sample driver
  always @(posedge clk_i) begin
    sample_t cur;
    sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur.phase = phase_i;
        cur.va = voltage_a_i;
        cur.ia = current_a_i;
        cur.ib = current_b_i;
        verdict_q.push_back(grid_verdict(cur));
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = sample_q.pop_front();
          in_valid_i <= 1'b1;
          phase_i <= nxt.phase;
          voltage_a_i <= nxt.va;
          current_a_i <= nxt.ia;
          current_b_i <= nxt.ib;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    verdict_rec_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result beat with nothing expected: status %0d fault %0d",
                     status_o, fault_code_o);
        end else begin
          want = verdict_q.pop_front();
          check_field("status", want.status, status_o);
          check_field("fault_code", want.fault, fault_code_o);
          check_field("peak_high", want.peak_high, peak_high_o);
          check_field("peak_low", want.peak_low, peak_low_o);
        end
      end
      out_ready_i <= ($urandom_range(99) >= gap_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ac_source_cycle_peak_checker_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: field extremes, classify with nothing seen
    push_sample(0, 0, 0, 0);
    push_sample(65535, 4095, 4095, 4095);
    push_sample(835, 4095, 0, 4095);
    push_sample(836, 0, 4095, 0);
    push_sample(65535, 2048, 2048, 2048);
    run_random(150);
    settle();

    program_cfg(834, 64667, band(3800, 300), band(2200, 1900), band(3000, 1100),
                band(3300, 800), band(3500, 600));
    push_sample(834, 2048, 2048, 2048);
    push_sample(65535, 2048, 2048, 2048);
    // all tracked samples zero still reads as nothing seen
    push_sample(835, 0, 2048, 2048);
    push_sample(30000, 0, 2048, 2048);
    push_sample(64667, 0, 2048, 2048);
    // over-current is dropped by reset and classify, kept while tracking
    push_sample(0, 2048, 4095, 2048);
    push_sample(1000, 4095, 4095, 2048);
    push_sample(30000, 0, 2048, 0);
    push_sample(64667, 2048, 0, 4095);
    push_class_cycle(2100, 2000);
    push_class_cycle(2600, 1500);
    push_class_cycle(3100, 1000);
    push_class_cycle(3600, 500);
    run_random(900);
    settle();

    program_cfg(0, 65535, band(0, 4095), band(4095, 0), '0, '1, band(0, 4095));
    run_random(150);
    settle();

    // start above stop: no tracking region
    program_cfg(40000, 20000, band(2048 + $urandom_range(0, 2047), $urandom_range(0, 2048)),
                band(2048 + $urandom_range(0, 400), 2048 - $urandom_range(0, 400)),
                band(2048 + $urandom_range(0, 1200), 2048 - $urandom_range(0, 1200)),
                band(2048 + $urandom_range(0, 1600), 2048 - $urandom_range(0, 1600)),
                band(2048 + $urandom_range(0, 2047), $urandom_range(0, 2048)));
    run_random(200);
    settle();

    // long stretch without gaps or stalls
    gap_pct = 0;
    program_cfg($urandom_range(0, 4000), $urandom_range(60000, 65535), CFG_W'($urandom),
                band(2048 + $urandom_range(0, 600), 2048 - $urandom_range(0, 600)),
                band(2048 + $urandom_range(0, 1200), 2048 - $urandom_range(0, 1200)),
                band(2048 + $urandom_range(0, 1600), 2048 - $urandom_range(0, 1600)),
                band(2048 + $urandom_range(0, 2047), $urandom_range(0, 2048)));
    run_random(300);
    settle();
    gap_pct = GAP_PCT;

    program_cfg(65535, 65535, '1, '1, '1, '1, '1);
    run_random(60);
    settle();

    program_cfg(0, 0, '0, '0, '0, '0, '0);
    run_random(60);
    settle();

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ac_source_cycle_peak_checker_core test passed");
    end else begin
      $display("ac_source_cycle_peak_checker_core test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/acpk_pkg.sv
hdl/acpk_eval.sv
hdl/ac_source_cycle_peak_checker_core.sv
hdl/acpk_checker.sv
tb/sv/tb_top.sv
